// ----- hdl/rfsm_pkg.sv -----
// Shared constants, types and helpers for the record filter substring match block.
package rfsm_pkg;

  localparam int CHAR_W         = 8;
  localparam int PATTERN_MAX    = 16;
  localparam int REQUIRED_SLOTS = 8;
  localparam int RECORD_MAX     = 1024;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int LEN_W    = 5;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_CHAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONCEPT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFICULTY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONCEPTS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONCEPT_COUNT = 3'd5;

  localparam logic [CHAR_W-1:0] DIFFICULTY_ANY = 8'hFF;

  typedef struct packed {
    logic shift;
    logic clear;
  } rfsm_cell_ctl_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ----- hdl/rfsm_in_if.sv -----
// Input item channel: valid, ready and the item fields.
interface rfsm_in_if;
  import rfsm_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [CHAR_W-1:0]   item_value;
  logic [INDEX_W-1:0]  record_index;

  modport source (output valid, mode, item_value, record_index, input ready);
  modport sink   (input valid, mode, item_value, record_index, output ready);
endinterface

// ----- hdl/rfsm_out_if.sv -----
// Result channel: valid, ready and the matched record index.
interface rfsm_out_if;
  import rfsm_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] matched_index;

  modport source (output valid, matched_index, input ready);
  modport sink   (input valid, matched_index, output ready);
endinterface

// ----- hdl/rfsm_cfg_if.sv -----
// Configuration write channel: valid, ready, register index and write data.
interface rfsm_cfg_if;
  import rfsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/rfsm_char_cell.sv -----
// One name character cell: holds a folded character; compares the incoming one with its pattern byte.
module rfsm_char_cell
  import rfsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rfsm_cell_ctl_t    ctl,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              valid_in,
  input  logic [CHAR_W-1:0] pat_char,
  input  logic              active,
  input  logic              hit_in,
  output logic [CHAR_W-1:0] char_out,
  output logic              valid_out,
  output logic              hit_out
);

  logic [CHAR_W-1:0] char_r;
  logic              valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      char_r <= char_in;
    end
  end

  // judge the character this cell takes on the shift
  assign hit_out   = hit_in && (!active || (valid_in && (char_in == pat_char)));
  assign char_out  = char_r;
  assign valid_out = valid_r;

endmodule

// ----- hdl/rfsm_concept_cell.sv -----
// One wanted concept slot: remembers whether its id has been seen in the current record.
module rfsm_concept_cell
  import rfsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rfsm_cell_ctl_t    ctl,
  input  logic [CHAR_W-1:0] concept_in,
  input  logic [CHAR_W-1:0] wanted_id,
  input  logic              active,
  input  logic              ok_in,
  output logic [CHAR_W-1:0] concept_out,
  output logic              ok_out
);

  logic found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ctl.shift && active && (concept_in == wanted_id)) begin
      found_r <= 1'b1;
    end
  end

  assign concept_out = concept_in;
  assign ok_out      = ok_in && (!active || found_r);

endmodule

// ----- hdl/record_filter_substring_match.sv -----
// Top level of the record filter: configuration registers, cell rows and result register.
//
// Takes one stream item per clock cycle while input is not stalled (name character,
// concept id or end of record) and gives at most one result per record: the record
// index, registered after its end item, when the name holds the pattern (case-insensitive
// ASCII, up to 16 characters), the difficulty fits and all wanted concepts were seen.
// A row of 16 character cells shifts the folded name along and compares every
// position with its pattern byte in the same cycle; a row of 8 slot cells
// tracks the wanted concepts. A two-entry output stage keeps input flowing
// while a result waits; input stalls only when both entries are full.
// Configuration is written through the cfg_ channel, one register per transfer.
module record_filter_substring_match
  import rfsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rfsm_in_if.sink    in_item,
  rfsm_out_if.source out_result,
  rfsm_cfg_if.sink   cfg_wr
);

  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [CHAR_W-1:0]     difficulty_r;
  logic [CFG_DATA_W-1:0] concepts_r;
  logic [COUNT_W-1:0]    concept_count_r;

  logic                  name_hit_r;
  logic                  out_valid_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic                  skid_valid_r;
  logic [INDEX_W-1:0]    skid_index_r;

  logic                  in_fire;
  logic                  char_fire;
  logic                  concept_fire;
  logic                  end_fire;
  logic [LEN_W-1:0]      len_eff;
  logic [COUNT_W-1:0]    slots_eff;
  logic [CHAR_W-1:0]     pat_bytes [PATTERN_MAX];
  logic [CHAR_W-1:0]     cell_pat  [PATTERN_MAX];
  logic                  cell_active [PATTERN_MAX];

  logic [CHAR_W-1:0]     chr   [PATTERN_MAX+1];
  logic                  vld   [PATTERN_MAX+1];
  logic                  hit   [PATTERN_MAX+1];
  logic [CHAR_W-1:0]     cid   [REQUIRED_SLOTS+1];
  logic                  cok   [REQUIRED_SLOTS+1];

  rfsm_cell_ctl_t        char_ctl;
  rfsm_cell_ctl_t        concept_ctl;

  logic                  diff_ok;
  logic                  match;
  logic                  push;
  logic                  out_take;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r       <= '0;
      pat_high_r      <= '0;
      pat_len_r       <= '0;
      difficulty_r    <= DIFFICULTY_ANY;
      concepts_r      <= '0;
      concept_count_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_PATTERN_LOW:   pat_low_r       <= cfg_wr.data;
        REG_PATTERN_HIGH:  pat_high_r      <= cfg_wr.data;
        REG_PATTERN_LEN:   pat_len_r       <= cfg_wr.data[LEN_W-1:0];
        REG_DIFFICULTY:    difficulty_r    <= cfg_wr.data[CHAR_W-1:0];
        REG_CONCEPTS:      concepts_r      <= cfg_wr.data;
        REG_CONCEPT_COUNT: concept_count_r <= cfg_wr.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.ready = !skid_valid_r;
  assign in_fire       = in_item.valid && in_item.ready;
  assign char_fire     = in_fire && (in_item.mode == MODE_CHAR);
  assign concept_fire  = in_fire && (in_item.mode == MODE_CONCEPT);
  assign end_fire      = in_fire && (in_item.mode == MODE_END);

  assign len_eff   = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;
  assign slots_eff = (concept_count_r > COUNT_W'(REQUIRED_SLOTS)) ?
                     COUNT_W'(REQUIRED_SLOTS) : concept_count_r;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pat_bytes[k]     = pat_low_r[8*k +: 8];
      pat_bytes[k + 8] = pat_high_r[8*k +: 8];
    end
  end

  // cell j sees pattern byte len-1-j
  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      cell_active[j] = LEN_W'(j) < len_eff;
      sel            = len_eff - LEN_W'(1) - LEN_W'(j);
      cell_pat[j]    = fold_case(pat_bytes[sel[3:0]]);
    end
  end

  assign char_ctl.shift    = char_fire;
  assign char_ctl.clear    = end_fire;
  assign concept_ctl.shift = concept_fire;
  assign concept_ctl.clear = end_fire;

  assign chr[0] = fold_case(in_item.item_value);
  assign vld[0] = 1'b1;
  assign hit[0] = 1'b1;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_char
    rfsm_char_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (char_ctl),
      .char_in   (chr[j]),
      .valid_in  (vld[j]),
      .pat_char  (cell_pat[j]),
      .active    (cell_active[j]),
      .hit_in    (hit[j]),
      .char_out  (chr[j+1]),
      .valid_out (vld[j+1]),
      .hit_out   (hit[j+1])
    );
  end

  assign cid[0] = in_item.item_value;
  assign cok[0] = 1'b1;

  for (genvar i = 0; i < REQUIRED_SLOTS; i++) begin : g_concept
    rfsm_concept_cell u_slot (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (concept_ctl),
      .concept_in  (cid[i]),
      .wanted_id   (concepts_r[8*i +: 8]),
      .active      (COUNT_W'(i) < slots_eff),
      .ok_in       (cok[i]),
      .concept_out (cid[i+1]),
      .ok_out      (cok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_hit_r <= 1'b0;
    end else if (end_fire) begin
      name_hit_r <= 1'b0;
    end else if (char_fire && hit[PATTERN_MAX]) begin
      name_hit_r <= 1'b1;
    end
  end

  assign diff_ok = (difficulty_r == DIFFICULTY_ANY) || (difficulty_r == in_item.item_value);
  assign match   = vld[1] && name_hit_r && diff_ok && cok[REQUIRED_SLOTS] &&
                   (32'(in_item.record_index) < RECORD_MAX);
  assign push    = end_fire && match;

  assign out_take = !out_valid_r || out_result.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_index_r <= skid_valid_r ? skid_index_r : in_item.record_index;
    end else if (push) begin
      skid_index_r <= in_item.record_index;
    end
  end

  assign out_result.valid         = out_valid_r;
  assign out_result.matched_index = out_index_r;

endmodule

// ----- bench/tb_record_filter_substring_match.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the record filter: streams records, predicts matches, checks results.
module tb_record_filter_substring_match;
  import rfsm_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd7;
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   ROUNDS        = 9;
  localparam int                   ROUND_ITEMS   = 200;
  localparam int                   DRAIN_CYCLES  = 2000;

  typedef enum {SET_QUIET, SET_FULL, SET_RANDOM} setting_kind_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  value;
    logic [INDEX_W-1:0] index;
  } stream_item_t;

  class record_matcher;
    logic [63:0]               pat_lo;
    logic [63:0]               pat_hi;
    logic [LEN_W-1:0]          pat_len;
    logic [CHAR_W-1:0]         diff_wanted;
    logic [63:0]               wanted_ids;
    logic [COUNT_W-1:0]        wanted_count;
    logic [CHAR_W-1:0]         name_tail [PATTERN_MAX];
    int unsigned               chars_seen;
    bit                        found_name;
    bit                        any_name;
    logic [REQUIRED_SLOTS-1:0] ids_found;
    logic [INDEX_W-1:0]        pending_matches [$];
    int unsigned               failures;
    int unsigned               matches_checked;
    int unsigned               items_taken;
    int unsigned               writes_taken;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      diff_wanted = DIFFICULTY_ANY;
      wanted_ids = '0;
      wanted_count = '0;
      clear_record();
    endfunction

    function void clear_record();
      foreach (name_tail[i]) name_tail[i] = '0;
      chars_seen = 0;
      found_name = 1'b0;
      any_name = 1'b0;
      ids_found = '0;
    endfunction

    function logic [CHAR_W-1:0] lower_ascii(logic [CHAR_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function logic [CHAR_W-1:0] pattern_byte(int k);
      if (k < 8) return pat_lo[8*k +: 8];
      if (k < 16) return pat_hi[8*(k-8) +: 8];
      return 8'h00;
    endfunction

    function int effective_len();
      return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    function int slots();
      return (wanted_count > REQUIRED_SLOTS) ? REQUIRED_SLOTS : int'(wanted_count);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      writes_taken++;
      case (idx)
        REG_PATTERN_LOW:   pat_lo = data;
        REG_PATTERN_HIGH:  pat_hi = data;
        REG_PATTERN_LEN:   pat_len = data[LEN_W-1:0];
        REG_DIFFICULTY:    diff_wanted = data[CHAR_W-1:0];
        REG_CONCEPTS:      wanted_ids = data;
        REG_CONCEPT_COUNT: wanted_count = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] v,
                            logic [INDEX_W-1:0] idx);
      int len;
      int n;
      int k;
      bit same;
      bit diff_ok;
      logic [REQUIRED_SLOTS:0] need;
      items_taken++;
      case (mode)
        MODE_CHAR: begin
          for (k = PATTERN_MAX - 1; k > 0; k--) name_tail[k] = name_tail[k-1];
          name_tail[0] = v;
          any_name = 1'b1;
          if (chars_seen < PATTERN_MAX) chars_seen++;
          len = effective_len();
          if (len == 0) begin
            found_name = 1'b1;
          end else if (chars_seen >= len) begin
            same = 1'b1;
            for (k = 0; k < len; k++) begin
              if (lower_ascii(pattern_byte(k)) != lower_ascii(name_tail[len-1-k])) same = 1'b0;
            end
            if (same) found_name = 1'b1;
          end
        end
        MODE_CONCEPT: begin
          n = slots();
          for (k = 0; k < n; k++) begin
            if (wanted_ids[8*k +: 8] == v) ids_found[k] = 1'b1;
          end
        end
        MODE_END: begin
          n = slots();
          need = (9'd1 << n) - 9'd1;
          diff_ok = (diff_wanted == DIFFICULTY_ANY) || (diff_wanted == v);
          if (any_name && found_name && diff_ok &&
              ((ids_found & need[REQUIRED_SLOTS-1:0]) == need[REQUIRED_SLOTS-1:0]))
            pending_matches.push_back(idx);
          clear_record();
        end
        default: ;
      endcase
    endfunction

    function void check_match(logic [INDEX_W-1:0] got);
      logic [INDEX_W-1:0] want;
      matches_checked++;
      if (pending_matches.size() == 0) begin
        failures++;
        $error("matched_index: expected none, actual %0d", got);
      end else begin
        want = pending_matches.pop_front();
        if (want !== got) begin
          failures++;
          $error("matched_index: expected %0d, actual %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rfsm_in_if  in_if();
  rfsm_out_if out_if();
  rfsm_cfg_if cfg_if();

  record_matcher sb = new();
  stream_item_t  record_items [$];
  int            in_gap_pct;
  int            out_stall_pct;
  int            items_sent;

  record_filter_substring_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_result (out_if),
    .cfg_wr     (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.take_item(in_if.mode, in_if.item_value, in_if.record_index);
      if (out_if.valid && out_if.ready) sb.check_match(out_if.matched_index);
    end
  end

  function automatic logic [CHAR_W-1:0] some_char();
    if ($urandom_range(3) == 0) return 8'($urandom);
    return (8'h41 + 8'($urandom_range(1))) | ($urandom_range(1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [CHAR_W-1:0] some_id();
    return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
  endfunction

  function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] low;
    low = c | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1)) return c ^ 8'h20;
    return c;
  endfunction

  function automatic void push_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] v, int lo);
    stream_item_t it;
    it.mode = mode;
    it.value = v;
    it.index = INDEX_W'($urandom);
    record_items.insert($urandom_range(record_items.size(), lo), it);
  endfunction

  function automatic void build_record();
    stream_item_t it;
    int len;
    int n;
    int k;
    int name_end;
    record_items.delete();
    len = sb.effective_len();
    n = sb.slots();
    if ($urandom_range(19) != 0) begin
      repeat ($urandom_range(4)) push_item(MODE_CHAR, some_char(), record_items.size());
      if ($urandom_range(99) < 65) begin
        for (k = 0; k < len; k++)
          push_item(MODE_CHAR, flip_case(sb.pattern_byte(k)), record_items.size());
      end
      repeat ($urandom_range(4)) push_item(MODE_CHAR, some_char(), record_items.size());
    end
    name_end = record_items.size();
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) != 0) push_item(MODE_CONCEPT, sb.wanted_ids[8*k +: 8], name_end);
    end
    repeat ($urandom_range(2)) push_item(MODE_CONCEPT, some_id(), name_end);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1)) begin
        it = {MODE_W'($urandom), CHAR_W'($urandom), INDEX_W'($urandom)};
        record_items.insert($urandom_range(record_items.size()), it);
      end
    end
    it.mode = MODE_END;
    it.value = ($urandom_range(9) < 7) ? sb.diff_wanted : 8'($urandom);
    it.index = INDEX_W'($urandom);
    record_items.push_back(it);
  endfunction

  function automatic logic [63:0] setting_value(logic [CFG_IDX_W-1:0] r, setting_kind_t kind);
    logic [63:0] v;
    int k;
    int pick;
    v = {$urandom, $urandom};
    if (kind == SET_QUIET) return 64'd0;
    if (kind == SET_FULL) return '1;
    pick = $urandom_range(19);
    case (r)
      REG_PATTERN_LOW, REG_PATTERN_HIGH: begin
        for (k = 0; k < 8; k++) begin
          if ($urandom_range(4) != 0) v[8*k +: 8] = some_char();
        end
      end
      REG_PATTERN_LEN: begin
        if (pick < 2) v[LEN_W-1:0] = '0;
        else if (pick < 15) v[LEN_W-1:0] = LEN_W'($urandom_range(4, 1));
        else if (pick < 19) v[LEN_W-1:0] = LEN_W'($urandom_range(16, 5));
        else v[LEN_W-1:0] = LEN_W'($urandom_range(31, 17));
        if ($urandom_range(1)) v[63:LEN_W] = '0;
      end
      REG_DIFFICULTY: begin
        if (pick < 8) v[CHAR_W-1:0] = DIFFICULTY_ANY;
        else if (pick < 16) v[CHAR_W-1:0] = 8'($urandom_range(3));
        else if (pick < 18) v[CHAR_W-1:0] = 8'h7F;
        if ($urandom_range(1)) v[63:CHAR_W] = '0;
      end
      REG_CONCEPTS: begin
        for (k = 0; k < 8; k++) v[8*k +: 8] = some_id();
      end
      REG_CONCEPT_COUNT: begin
        if (pick < 17) v[COUNT_W-1:0] = COUNT_W'($urandom_range(3));
        else v[COUNT_W-1:0] = COUNT_W'($urandom_range(15, 4));
        if ($urandom_range(1)) v[63:COUNT_W] = '0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] v,
                           logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < in_gap_pct) begin
      in_if.valid = 1'b0;
      in_if.mode = MODE_W'($urandom);
      in_if.item_value = CHAR_W'($urandom);
      in_if.record_index = INDEX_W'($urandom);
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.mode = mode;
    in_if.item_value = v;
    in_if.record_index = idx;
    if (mode != MODE_SPARE) items_sent++;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_if.valid = 1'b0;
    while (sb.pending_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(setting_kind_t kind);
    int i;
    logic [CFG_IDX_W-1:0] r;
    wait_quiet();
    for (i = 0; i <= REG_CONCEPT_COUNT; i++) begin
      r = CFG_IDX_W'(i);
      write_setting(r, setting_value(r, kind));
    end
    if (kind == SET_RANDOM && $urandom_range(2) == 0)
      write_setting(REG_SPARE, {$urandom, $urandom});
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_record(int split);
    int i;
    logic [CFG_IDX_W-1:0] r;
    for (i = 0; i < record_items.size(); i++) begin
      if (i == split) begin
        wait_quiet();
        r = CFG_IDX_W'($urandom_range(REG_CONCEPT_COUNT));
        write_setting(r, setting_value(r, SET_RANDOM));
        cfg_if.valid = 1'b0;
      end
      send_item(record_items[i].mode, record_items[i].value, record_items[i].index);
    end
  endtask

  initial begin
    logic [127:0] long_name;
    int k;
    int round;
    int goal;
    int rec;
    int drained;
    setting_kind_t kind;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.item_value = '0;
    in_if.record_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    items_sent = 0;
    in_gap_pct = 26;
    out_stall_pct = 56;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_item(MODE_END, 8'h00, 10'h3FF);
    send_item(MODE_CHAR, 8'h00, 10'h000);
    send_item(MODE_END, 8'hFF, 10'h000);
    send_item(MODE_SPARE, 8'hFF, 10'h3FF);
    send_item(MODE_CHAR, 8'h78, 10'h000);
    send_item(MODE_END, 8'h80, 10'h005);
    wait_quiet();
    write_setting(REG_PATTERN_LOW, 64'h7B7A61605B5A4140);
    write_setting(REG_PATTERN_HIGH, 64'h7F7E3930714DFF00);
    write_setting(REG_PATTERN_LEN, 64'd31);
    write_setting(REG_DIFFICULTY, 64'd0);
    write_setting(REG_CONCEPTS, 64'd0);
    write_setting(REG_CONCEPT_COUNT, 64'hF);
    cfg_if.valid = 1'b0;
    long_name = {64'h7F7E3930516DFF00, 64'h7B5A41605B7A6140};
    for (k = 0; k < PATTERN_MAX; k++) send_item(MODE_CHAR, long_name[8*k +: 8], 10'h000);
    send_item(MODE_CONCEPT, 8'h00, 10'h000);
    send_item(MODE_END, 8'h00, 10'h2AA);

    for (round = 0; round < ROUNDS; round++) begin
      in_gap_pct = (round < 3) ? 26 : (round < 6) ? 56 : 0;
      out_stall_pct = (round < 3) ? 56 : (round < 6) ? 26 : 0;
      kind = (round == 0) ? SET_QUIET : (round == 4) ? SET_FULL : SET_RANDOM;
      apply_settings(kind);
      goal = items_sent + ROUND_ITEMS;
      rec = 0;
      while (items_sent < goal) begin
        build_record();
        send_record((rec == 2) ? $urandom_range(record_items.size() - 1) : -1);
        rec++;
      end
    end

    in_if.valid = 1'b0;
    drained = 0;
    while (sb.pending_matches.size() != 0 && drained < DRAIN_CYCLES) begin
      @(negedge clk);
      drained++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (sb.pending_matches.size() != 0) begin
      sb.failures++;
      $error("matched_index: expected %0d, actual none", sb.pending_matches.pop_front());
    end

    $display("Streamed %0d items (%0d records matched) across %0d register settings,",
             sb.items_taken, sb.matches_checked, ROUNDS + 2);
    $display("with %0d register writes and three sender/receiver stall profiles.",
             sb.writes_taken);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
